// ===== hdl/cjd_pkg.sv =====
// Package with constants and small lookup functions for the calendar to Julian day core.
`default_nettype none

package cjd_pkg;

  // Field widths of the request and result channels.
  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 14;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int MjdW    = 24;
  localparam int ModW    = 11;

  // Calendar constants.
  localparam int GapYear   = 1582;
  localparam int GapMonth  = 10;
  localparam int GapFirst  = 5;
  localparam int GapLast   = 14;
  localparam int JulOffset = 4716;
  localparam int JulBias   = 1181;
  localparam int MjdBase   = 679004;
  localparam int DaysYear  = 365;

  // Division by 100 through a reciprocal multiply, exact for any 14-bit value.
  localparam int Div100Mul   = 5243;
  localparam int Div100Shift = 19;
  localparam int QuotW       = 8;

  typedef logic [QuotW-1:0] quot_t;

  // Status codes.
  typedef enum logic {
    ST_OK  = 1'b0,
    ST_GAP = 1'b1
  } status_t;

  // Floor of a 14-bit year divided by 100.
  function automatic quot_t div100(input logic [YearW-1:0] y);
    logic [YearW+13-1:0] prod;
    prod = {13'd0, y} * (YearW+13)'(Div100Mul);
    return quot_t'(prod >> Div100Shift);
  endfunction

  // Floor of 30.6 times the shifted month (valid for 4 to 16).
  function automatic logic [8:0] month_term(input logic [4:0] m);
    logic [8:0] t;
    case (m)
      5'd4:    t = 9'd122;
      5'd5:    t = 9'd153;
      5'd6:    t = 9'd183;
      5'd7:    t = 9'd214;
      5'd8:    t = 9'd244;
      5'd9:    t = 9'd275;
      5'd10:   t = 9'd306;
      5'd11:   t = 9'd336;
      5'd12:   t = 9'd367;
      5'd13:   t = 9'd397;
      5'd14:   t = 9'd428;
      5'd15:   t = 9'd459;
      5'd16:   t = 9'd489;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // Days in a month, February taken as a leap February.
  function automatic logic [4:0] month_len(input logic [MonthW-1:0] mo);
    logic [4:0] n;
    case (mo)
      4'd1:    n = 5'd31;
      4'd2:    n = 5'd29;
      4'd3:    n = 5'd31;
      4'd4:    n = 5'd30;
      4'd5:    n = 5'd31;
      4'd6:    n = 5'd30;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd31;
      4'd9:    n = 5'd30;
      4'd10:   n = 5'd31;
      4'd11:   n = 5'd30;
      4'd12:   n = 5'd31;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/calendar_to_julian_day_core.sv =====
// Calendar date and time to modified Julian day and minute of day, two register stages.
//
// Channel   Direction  Handshake            Payload
// in_*      input      in_valid/in_ready    day, month, year, before_christ, hour, minute
// out_*     output     out_valid/out_ready  status, mjd_day, minute_of_day, date_valid
//
// One request is accepted per cycle unless the output stalls.
// The conversion is a single pass of constant multiplies, a small month table and one
// wide sum between the input register and the result register.
// Reset (rst_n low, synchronous) empties both stages; payload registers are not reset.
// A stalled result holds the output register; the input stage then fills and in_ready drops.
`default_nettype none

module calendar_to_julian_day_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cjd_pkg::DayW-1:0]      in_day,
  input  wire logic [cjd_pkg::MonthW-1:0]    in_month,
  input  wire logic [cjd_pkg::YearW-1:0]     in_year,
  input  wire logic                          in_before_christ,
  input  wire logic [cjd_pkg::HourW-1:0]     in_hour,
  input  wire logic [cjd_pkg::MinuteW-1:0]   in_minute,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_status,
  output logic signed [cjd_pkg::MjdW-1:0]    out_mjd_day,
  output logic [cjd_pkg::ModW-1:0]           out_minute_of_day,
  output logic                               out_date_valid
);
  import cjd_pkg::*;

  localparam int SW = 16;  // signed year width
  localparam int AW = 26;  // signed day-sum width

  // Input stage registers.
  logic                 s1_valid_r;
  logic [DayW-1:0]      s1_day_r;
  logic [MonthW-1:0]    s1_month_r;
  logic [YearW-1:0]     s1_year_r;
  logic                 s1_bc_r;
  logic [HourW-1:0]     s1_hour_r;
  logic [MinuteW-1:0]   s1_minute_r;

  // Result registers.
  logic                 out_valid_r;
  logic                 status_r;
  logic signed [MjdW-1:0] mjd_r;
  logic [ModW-1:0]      mod_r;
  logic                 dvalid_r;

  // Next values of the result registers.
  logic                 status_nxt;
  logic signed [MjdW-1:0] mjd_nxt;
  logic [ModW-1:0]      mod_nxt;
  logic                 dvalid_nxt;

  logic s1_adv;
  logic in_acc;

  // Handshake: the result register frees when empty or taken, the input stage follows.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Conversion datapath.
  logic                 gap;
  logic                 julian;
  logic                 early_month;
  logic signed [SW-1:0] y_base;
  logic signed [SW-1:0] y_adj;
  logic [4:0]           m_adj;
  logic signed [SW-1:0] jul_sum;
  logic signed [AW-1:0] b_term;
  logic [YearW-1:0]     y_pos;
  quot_t                q100;
  logic signed [AW-1:0] sum;
  quot_t                yq_now;
  quot_t                yq_prev;
  logic                 div100_ok;
  logic                 leap;
  logic [4:0]           day_lim;
  logic                 date_ok;

  always_comb begin
    gap = !s1_bc_r && (s1_year_r == YearW'(GapYear)) && (s1_month_r == MonthW'(GapMonth))
          && (s1_day_r >= DayW'(GapFirst)) && (s1_day_r <= DayW'(GapLast));

    // Julian calendar up to 14 Oct 1582 and for every year before Christ.
    if (s1_bc_r || (s1_year_r < YearW'(GapYear))) begin
      julian = 1'b1;
    end else if (s1_year_r > YearW'(GapYear)) begin
      julian = 1'b0;
    end else begin
      julian = !((s1_month_r > MonthW'(GapMonth)) ||
                 ((s1_month_r == MonthW'(GapMonth)) && (s1_day_r > DayW'(GapLast))));
    end

    // Years before Christ map to one minus the year; year zero stays zero.
    if (s1_bc_r && (s1_year_r != '0)) begin
      y_base = SW'(1) - SW'(s1_year_r);
    end else begin
      y_base = SW'(s1_year_r);
    end

    // January and February count as months 13 and 14 of the previous year.
    early_month = (s1_month_r <= MonthW'(2));
    if (early_month) begin
      y_adj = y_base - SW'(1);
      m_adj = 5'(s1_month_r) + 5'd13;
    end else begin
      y_adj = y_base;
      m_adj = 5'(s1_month_r) + 5'd1;
    end

    // Century correction term of either calendar.
    jul_sum = y_adj + SW'(JulOffset);
    y_pos   = y_adj[YearW-1:0];
    q100    = div100(y_pos);
    if (julian) begin
      b_term = AW'(jul_sum >>> 2) - AW'(JulBias);
    end else begin
      b_term = AW'({q100[QuotW-1:2]}) - AW'(q100) + AW'(y_pos[YearW-1:2]);
    end

    sum = AW'(y_adj) * AW'(DaysYear) - AW'(MjdBase) + b_term
          + AW'(month_term(m_adj)) + AW'(s1_day_r);

    status_nxt = gap ? ST_GAP : ST_OK;
    mjd_nxt    = gap ? '0 : sum[MjdW-1:0];
    mod_nxt    = ModW'(s1_hour_r) * ModW'(60) + ModW'(s1_minute_r);

    // Gregorian leap rule on the year as written; a multiple of 100 shows as a quotient step.
    yq_now    = div100(s1_year_r);
    yq_prev   = div100(s1_year_r - YearW'(1));
    div100_ok = (s1_year_r == '0) || (yq_now != yq_prev);
    leap      = ((s1_year_r[1:0] == 2'd0) && !div100_ok) ||
                (div100_ok && (yq_now[1:0] == 2'd0));

    day_lim = month_len(s1_month_r);
    if ((s1_month_r == MonthW'(2)) && !leap) begin
      day_lim = 5'd28;
    end
    date_ok    = (s1_day_r != '0) && (day_lim != '0) && (s1_day_r <= day_lim);
    dvalid_nxt = date_ok && (s1_hour_r <= HourW'(23)) && (s1_minute_r <= MinuteW'(59));
  end

  // Pipeline control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_day_r    <= in_day;
      s1_month_r  <= in_month;
      s1_year_r   <= in_year;
      s1_bc_r     <= in_before_christ;
      s1_hour_r   <= in_hour;
      s1_minute_r <= in_minute;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      status_r <= status_nxt;
      mjd_r    <= mjd_nxt;
      mod_r    <= mod_nxt;
      dvalid_r <= dvalid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_mjd_day       = mjd_r;
  assign out_minute_of_day = mod_r;
  assign out_date_valid    = dvalid_r;

`ifndef ASSERT_OFF
  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An empty result register never blocks requests.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

  // A held request moves into the result register whenever it is free.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid)
    else $error("request lost between stages");

  // A gap date always reports a zero day number.
  a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_mjd_day == '0))
    else $error("gap date with nonzero day number");
`endif

endmodule

`default_nettype wire
